// ===== src/dbc_pkg.sv =====
// shared types, codes and constants for the dual battery cycle controller
// no dependencies; imported by every module of the block
`default_nettype none

package dbc_pkg;

   // item kinds carried on req_tuser
   localparam logic [1:0] OP_ENTER = 2'd0;
   localparam logic [1:0] OP_TICK  = 2'd1;
   localparam logic [1:0] OP_LEAVE = 2'd2;

   // battery modes
   localparam logic [1:0] MODE_STANDBY   = 2'd0;
   localparam logic [1:0] MODE_CHARGE    = 2'd1;
   localparam logic [1:0] MODE_DISCHARGE = 2'd2;

   // control register indexes
   localparam logic [2:0] CSR_CHARGE_PERIOD   = 3'd0;
   localparam logic [2:0] CSR_DISCHARGE_LIMIT = 3'd1;
   localparam logic [2:0] CSR_BAT1_ENABLE     = 3'd2;
   localparam logic [2:0] CSR_BAT2_ENABLE     = 3'd3;
   localparam logic [2:0] CSR_BAT1_VMAX       = 3'd4;
   localparam logic [2:0] CSR_BAT1_VMIN       = 3'd5;
   localparam logic [2:0] CSR_BAT2_VMAX       = 3'd6;
   localparam logic [2:0] CSR_BAT2_VMIN       = 3'd7;

   localparam int          NUM_BAT       = 2;
   localparam logic [31:0] REPORT_PERIOD = 32'd100;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] time_now;
      logic [15:0] volt_one;
      logic [15:0] volt_two;
   } item_type;

   typedef struct packed {
      logic [31:0]                    charge_period;
      logic [31:0]                    discharge_limit;
      logic [NUM_BAT-1:0]             bat_enable;
      logic [NUM_BAT-1:0][15:0]       bat_vmax;
      logic [NUM_BAT-1:0][15:0]       bat_vmin;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  bat1_mode;
      logic [1:0]  bat2_mode;
      logic        active_battery;
      logic [15:0] bat1_cycles;
      logic [15:0] bat2_cycles;
      logic        switched;
      logic        report_due;
   } result_type;

endpackage

`default_nettype wire

// ===== src/dbc_csr.sv =====
// control registers of the dual battery cycle controller
// depends on dbc_pkg for register indexes and the cfg_type bundle
`default_nettype none

module dbc_csr (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [2:0]        csr_addr,
   input  wire logic [31:0]       csr_wdata,
   output dbc_pkg::cfg_type       cfg
);
   import dbc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_CHARGE_PERIOD:   cfg_in.charge_period   = csr_wdata;
            CSR_DISCHARGE_LIMIT: cfg_in.discharge_limit = csr_wdata;
            CSR_BAT1_ENABLE:     cfg_in.bat_enable[0]   = csr_wdata[0];
            CSR_BAT2_ENABLE:     cfg_in.bat_enable[1]   = csr_wdata[0];
            CSR_BAT1_VMAX:       cfg_in.bat_vmax[0]     = csr_wdata[15:0];
            CSR_BAT1_VMIN:       cfg_in.bat_vmin[0]     = csr_wdata[15:0];
            CSR_BAT2_VMAX:       cfg_in.bat_vmax[1]     = csr_wdata[15:0];
            CSR_BAT2_VMIN:       cfg_in.bat_vmin[1]     = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.charge_period   <= '0;
         cfg_ff.discharge_limit <= '0;
         cfg_ff.bat_enable      <= '1;
         cfg_ff.bat_vmax        <= '1;
         cfg_ff.bat_vmin        <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== src/dbc_engine.sv =====
// cycle state and next-state logic: role swap, discharge stop, voltage cutoffs
// depends on dbc_pkg; state advances on fire, result is combinational
`default_nettype none

module dbc_engine (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              fire,
   input  dbc_pkg::item_type      item,
   input  dbc_pkg::cfg_type       cfg,
   output dbc_pkg::result_type    result
);
   import dbc_pkg::*;

   logic                          sel_ff, sel_in;
   logic [31:0]                   switch_stamp_ff, switch_stamp_in;
   logic [31:0]                   report_stamp_ff, report_stamp_in;
   logic [NUM_BAT-1:0][1:0]       mode_ff, mode_in;
   logic [NUM_BAT-1:0][15:0]      count_ff, count_in;

   logic [31:0]                   elapsed;
   logic [31:0]                   elapsed_rep;
   logic                          expire;
   logic                          stop_dis;
   logic                          rep_due;
   logic                          is_tick;
   logic [NUM_BAT-1:0][15:0]      volt;
   logic [NUM_BAT-1:0][1:0]       tick_mode;
   logic [NUM_BAT-1:0][1:0]       swap_mode;
   logic [NUM_BAT-1:0][1:0]       limit_mode;
   logic [NUM_BAT-1:0][15:0]      tick_count;

   assign volt[0]     = item.volt_one;
   assign volt[1]     = item.volt_two;
   assign is_tick     = (item.op == OP_TICK);
   assign elapsed     = item.time_now - switch_stamp_ff;
   assign elapsed_rep = item.time_now - report_stamp_ff;
   assign expire      = elapsed > cfg.charge_period;
   // on a swap tick the elapsed time counts as zero, so no stop then
   assign stop_dis    = !expire && (elapsed > cfg.discharge_limit);
   assign rep_due     = elapsed_rep > REPORT_PERIOD;

   always_comb begin
      for (int i = 0; i < NUM_BAT; i++) begin
         // the active battery discharges, the other one takes over charging
         if (sel_ff == i[0]) begin
            swap_mode[i] = (cfg.bat_enable[i] && volt[i] > cfg.bat_vmin[i]) ?
                           MODE_DISCHARGE : MODE_STANDBY;
         end else begin
            swap_mode[i] = (cfg.bat_enable[i] && volt[i] < cfg.bat_vmax[i]) ?
                           MODE_CHARGE : MODE_STANDBY;
         end
         limit_mode[i] = expire ? swap_mode[i] : mode_ff[i];
         if (stop_dis && sel_ff != i[0]) begin
            limit_mode[i] = MODE_STANDBY;
         end
         tick_mode[i] = limit_mode[i];
         if (rep_due) begin
            if (volt[i] > cfg.bat_vmax[i] && limit_mode[i] == MODE_CHARGE) begin
               tick_mode[i] = MODE_STANDBY;
            end
            if (volt[i] < cfg.bat_vmin[i] && limit_mode[i] == MODE_DISCHARGE) begin
               tick_mode[i] = MODE_STANDBY;
            end
         end
         tick_count[i] = (expire && sel_ff != i[0]) ? count_ff[i] + 16'd1 : count_ff[i];
      end
   end

   always_comb begin
      sel_in          = sel_ff;
      switch_stamp_in = switch_stamp_ff;
      report_stamp_in = report_stamp_ff;
      mode_in         = mode_ff;
      count_in        = count_ff;
      case (item.op)
         OP_ENTER: begin
            sel_in          = 1'b0;
            switch_stamp_in = item.time_now;
            report_stamp_in = item.time_now;
            mode_in         = {NUM_BAT{MODE_STANDBY}};
            count_in        = '0;
         end
         OP_TICK: begin
            mode_in  = tick_mode;
            count_in = tick_count;
            if (expire) begin
               sel_in          = ~sel_ff;
               switch_stamp_in = item.time_now;
            end
            if (rep_due) begin
               report_stamp_in = item.time_now;
            end
         end
         OP_LEAVE: begin
            mode_in = {NUM_BAT{MODE_STANDBY}};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff          <= 1'b0;
         switch_stamp_ff <= '0;
         report_stamp_ff <= '0;
         mode_ff         <= {NUM_BAT{MODE_STANDBY}};
         count_ff        <= '0;
      end else if (fire) begin
         sel_ff          <= sel_in;
         switch_stamp_ff <= switch_stamp_in;
         report_stamp_ff <= report_stamp_in;
         mode_ff         <= mode_in;
         count_ff        <= count_in;
      end
   end

   assign result.bat1_mode      = mode_in[0];
   assign result.bat2_mode      = mode_in[1];
   assign result.active_battery = sel_in;
   assign result.bat1_cycles    = count_in[0];
   assign result.bat2_cycles    = count_in[1];
   assign result.switched       = is_tick && expire;
   assign result.report_due     = is_tick && rep_due;

endmodule

`default_nettype wire

// ===== src/dual_battery_cycle_controller.sv =====
// top level of the dual battery cycle controller: input register, engine, result register
// depends on dbc_pkg, dbc_csr and dbc_engine
//
//   channel   | direction | payload
//   req_      | in        | tuser: op; tdata: time_now, volt_one, volt_two
//   rsp_      | out       | tdata: modes, active battery, cycle counts, switched, report_due
//   csr_      | in        | write enable, register index, 32-bit write data
//
// one word per cycle while rsp_tready stays high; rsp words come from the result register
// the input register feeds the engine, whose state and the result register load together
// a stalled rsp side holds the result register while one more word waits in the input register
// synchronous reset clears control state and cycle state and sets the control registers to defaults
`default_nettype none

module dual_battery_cycle_controller (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_tuser,   // op
   input  wire logic [63:0] req_tdata,   // time_now, volt_one, volt_two
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // bat1_mode, bat2_mode, active_battery,
                                         // bat1_cycles, bat2_cycles, switched,
                                         // report_due, zero pad
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_addr,
   input  wire logic [31:0] csr_wdata
);
   import dbc_pkg::*;

   cfg_type    cfg;
   item_type   item_ff, item_in;
   logic       in_valid_ff, in_valid_in;
   result_type res_ff;
   result_type res_comb;
   logic       out_valid_ff, out_valid_in;
   logic       advance;
   logic       req_fire;

   assign advance  = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire = req_tvalid && req_tready;

   assign item_in.op       = req_tuser;
   assign item_in.time_now = req_tdata[31:0];
   assign item_in.volt_one = req_tdata[47:32];
   assign item_in.volt_two = req_tdata[63:48];

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   dbc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dbc_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (res_comb)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= item_in;
      end
      if (advance) begin
         res_ff <= res_comb;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, res_ff.report_due, res_ff.switched, res_ff.bat2_cycles,
                        res_ff.bat1_cycles, res_ff.active_battery, res_ff.bat2_mode,
                        res_ff.bat1_mode};

endmodule

`default_nettype wire

// ===== test/dbc_result_checker.sv =====
// result checker for the dual battery cycle controller: watches req, rsp and csr traffic,
// predicts every rsp word from its own copy of the cycler state and compares field by field
// depends on dbc_pkg
module dbc_result_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [1:0]  req_tuser,
   input  wire logic [63:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [39:0] rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_addr,
   input  wire logic [31:0] csr_wdata,
   output int               mismatch_count,
   output int               pending_results
);
   import dbc_pkg::*;

   cfg_type     settings;
   logic        active_bat;
   logic [31:0] switch_stamp;
   logic [31:0] report_stamp;
   logic [1:0]  modes [NUM_BAT];
   logic [15:0] cycle_count [NUM_BAT];
   result_type  predicted_results [$];
   int          failures = 0;

   assign mismatch_count = failures;

   task automatic restore_defaults();
      settings.charge_period   = '0;
      settings.discharge_limit = '0;
      settings.bat_enable      = '1;
      for (int b = 0; b < NUM_BAT; b++) begin
         settings.bat_vmax[b] = 16'hFFFF;
         settings.bat_vmin[b] = 16'h0000;
         modes[b]             = MODE_STANDBY;
         cycle_count[b]       = '0;
      end
      active_bat   = 1'b0;
      switch_stamp = '0;
      report_stamp = '0;
   endtask

   function automatic result_type advance_cycler(item_type it);
      result_type  res;
      logic [31:0] since_switch;
      logic [31:0] since_report;
      logic [15:0] volts [NUM_BAT];
      logic        sel;
      res      = '0;
      volts[0] = it.volt_one;
      volts[1] = it.volt_two;
      case (it.op)
         OP_ENTER: begin
            modes[0]       = MODE_STANDBY;
            modes[1]       = MODE_STANDBY;
            active_bat     = 1'b0;
            switch_stamp   = it.time_now;
            report_stamp   = it.time_now;
            cycle_count[0] = '0;
            cycle_count[1] = '0;
         end
         OP_TICK: begin
            since_switch = it.time_now - switch_stamp;
            since_report = it.time_now - report_stamp;
            sel          = active_bat;
            if (since_switch > settings.charge_period) begin
               modes[0] = MODE_STANDBY;
               modes[1] = MODE_STANDBY;
               if (settings.bat_enable[sel] && volts[sel] > settings.bat_vmin[sel])
                  modes[sel] = MODE_DISCHARGE;
               sel = !sel;
               if (settings.bat_enable[sel] && volts[sel] < settings.bat_vmax[sel])
                  modes[sel] = MODE_CHARGE;
               cycle_count[sel] = cycle_count[sel] + 16'd1;
               active_bat       = sel;
               switch_stamp     = it.time_now;
               since_switch     = '0;
               res.switched     = 1'b1;
            end
            // the battery not selected for charging is the discharging one
            if (since_switch > settings.discharge_limit)
               modes[!sel] = MODE_STANDBY;
            if (since_report > REPORT_PERIOD) begin
               report_stamp = it.time_now;
               for (int b = 0; b < NUM_BAT; b++)
                  if (volts[b] > settings.bat_vmax[b] && modes[b] == MODE_CHARGE)
                     modes[b] = MODE_STANDBY;
               for (int b = 0; b < NUM_BAT; b++)
                  if (volts[b] < settings.bat_vmin[b] && modes[b] == MODE_DISCHARGE)
                     modes[b] = MODE_STANDBY;
               res.report_due = 1'b1;
            end
         end
         OP_LEAVE: begin
            modes[0] = MODE_STANDBY;
            modes[1] = MODE_STANDBY;
         end
         default: ;
      endcase
      res.bat1_mode      = modes[0];
      res.bat2_mode      = modes[1];
      res.active_battery = active_bat;
      res.bat1_cycles    = cycle_count[0];
      res.bat2_cycles    = cycle_count[1];
      return res;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want_v, got_v);
      if (got_v !== want_v) begin
         failures++;
         if (failures <= 10)
            $display("rsp mismatch in %s: expected %0h, got %0h", name, want_v, got_v);
      end
   endtask

   always @(posedge clock) begin : watch
      item_type   item;
      result_type want;
      result_type got;
      if (reset) begin
         restore_defaults();
         predicted_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_CHARGE_PERIOD:   settings.charge_period   = csr_wdata;
               CSR_DISCHARGE_LIMIT: settings.discharge_limit = csr_wdata;
               CSR_BAT1_ENABLE:     settings.bat_enable[0]   = csr_wdata[0];
               CSR_BAT2_ENABLE:     settings.bat_enable[1]   = csr_wdata[0];
               CSR_BAT1_VMAX:       settings.bat_vmax[0]     = csr_wdata[15:0];
               CSR_BAT1_VMIN:       settings.bat_vmin[0]     = csr_wdata[15:0];
               CSR_BAT2_VMAX:       settings.bat_vmax[1]     = csr_wdata[15:0];
               CSR_BAT2_VMIN:       settings.bat_vmin[1]     = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_results.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("rsp word %0h arrived with nothing outstanding", rsp_tdata);
            end else begin
               want               = predicted_results.pop_front();
               got.bat1_mode      = rsp_tdata[1:0];
               got.bat2_mode      = rsp_tdata[3:2];
               got.active_battery = rsp_tdata[4];
               got.bat1_cycles    = rsp_tdata[20:5];
               got.bat2_cycles    = rsp_tdata[36:21];
               got.switched       = rsp_tdata[37];
               got.report_due     = rsp_tdata[38];
               check_field("bat1_mode", want.bat1_mode, got.bat1_mode);
               check_field("bat2_mode", want.bat2_mode, got.bat2_mode);
               check_field("active_battery", want.active_battery, got.active_battery);
               check_field("bat1_cycles", want.bat1_cycles, got.bat1_cycles);
               check_field("bat2_cycles", want.bat2_cycles, got.bat2_cycles);
               check_field("switched", want.switched, got.switched);
               check_field("report_due", want.report_due, got.report_due);
            end
         end
         if (req_tvalid && req_tready) begin
            item.op       = req_tuser;
            item.time_now = req_tdata[31:0];
            item.volt_one = req_tdata[47:32];
            item.volt_two = req_tdata[63:48];
            predicted_results.push_back(advance_cycler(item));
         end
      end
      pending_results <= predicted_results.size();
   end

endmodule

// ===== test/dual_battery_cycle_controller_test.sv =====
// top of the dual battery cycle controller testbench: clock, reset, csr settings and
// req/rsp traffic with idle profiles; depends on dbc_pkg, the block and dbc_result_checker
module dual_battery_cycle_controller_test;
   import dbc_pkg::*;

   // op code outside the defined set, the block must leave its state alone
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int         LONG_HOLD = 300;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser  = '0;
   logic [63:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_we     = 1'b0;
   logic [2:0]  csr_addr   = '0;
   logic [31:0] csr_wdata  = '0;
   int          mismatch_count;
   int          pending_results;

   int send_pct      = 0;
   int stall_pct     = 0;
   int holds_asked   = 0;
   int holds_served  = 0;
   int hold_left     = 0;
   int words_sent    = 0;
   int settings_used = 0;

   dual_battery_cycle_controller u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   dbc_result_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tuser       (req_tuser),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   always #2 clock = ~clock;

   initial begin
      #2_400_000;
      $display("Verification failed");
      $finish;
   end

   // rsp side: random stalls, or a long hold-off when the stimulus asks for one
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (holds_served != holds_asked) begin
         rsp_tready   <= 1'b0;
         hold_left    <= LONG_HOLD;
         holds_served <= holds_served + 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic cfg_type make_settings(logic [31:0] period, limit, logic en1, en2,
                                             logic [15:0] vmax1, vmin1, vmax2, vmin2);
      cfg_type c;
      c.charge_period   = period;
      c.discharge_limit = limit;
      c.bat_enable      = {en2, en1};
      c.bat_vmax[0]     = vmax1;
      c.bat_vmin[0]     = vmin1;
      c.bat_vmax[1]     = vmax2;
      c.bat_vmin[1]     = vmin2;
      return c;
   endfunction

   // mostly inside the window, some right at its edges, some anywhere
   function automatic logic [15:0] pick_volt(logic [15:0] lo, hi);
      logic [31:0] raw;
      int          roll;
      raw  = $urandom;
      roll = $urandom_range(99);
      if (roll < 15 || lo > hi)
         return raw[15:0];
      if (roll < 35) begin
         case (raw[1:0])
            2'd0:    return lo;
            2'd1:    return hi;
            2'd2:    return lo - 16'd1;
            default: return hi + 16'd1;
         endcase
      end
      raw = $urandom_range(hi, lo);
      return raw[15:0];
   endfunction

   task automatic put_reg(input logic [2:0] idx, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic write_settings(input cfg_type c);
      put_reg(CSR_CHARGE_PERIOD, c.charge_period);
      put_reg(CSR_DISCHARGE_LIMIT, c.discharge_limit);
      put_reg(CSR_BAT1_ENABLE, {31'd0, c.bat_enable[0]});
      put_reg(CSR_BAT2_ENABLE, {31'd0, c.bat_enable[1]});
      put_reg(CSR_BAT1_VMAX, {16'd0, c.bat_vmax[0]});
      put_reg(CSR_BAT1_VMIN, {16'd0, c.bat_vmin[0]});
      put_reg(CSR_BAT2_VMAX, {16'd0, c.bat_vmax[1]});
      put_reg(CSR_BAT2_VMIN, {16'd0, c.bat_vmin[1]});
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // returns in the cycle the word is taken, with tvalid still high
   task automatic send_item(input logic [1:0] op, input logic [31:0] stamp,
                            input logic [15:0] v1, v2);
      while (send_pct != 0 && $urandom_range(99) < send_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {v2, v1, stamp};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      words_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do
         @(posedge clock);
      while (pending_results != 0);
   endtask

   task automatic run_phase(input cfg_type c, input int items, input int send_idle,
                            input int stall, input int step_max, input bit hold_mid);
      logic [31:0] stamp;
      logic [1:0]  op;
      int          roll;
      write_settings(c);
      send_pct  = send_idle;
      stall_pct = stall;
      stamp     = $urandom;
      if ($urandom_range(9) < 3)
         stamp = 32'hFFFF_FFFF - $urandom_range(500);
      send_item(OP_ENTER, stamp, pick_volt(c.bat_vmin[0], c.bat_vmax[0]),
                pick_volt(c.bat_vmin[1], c.bat_vmax[1]));
      for (int k = 0; k < items; k++) begin
         if (k == items / 2) begin
            if (hold_mid)
               holds_asked++;
            else
               drain();
         end
         roll = $urandom_range(99);
         if (roll < 4)
            op = OP_ENTER;
         else if (roll < 8)
            op = OP_LEAVE;
         else if (roll < 10)
            op = OP_UNUSED;
         else
            op = OP_TICK;
         if ($urandom_range(99) < 3)
            stamp = $urandom;
         else
            stamp = stamp + $urandom_range(step_max);
         send_item(op, stamp, pick_volt(c.bat_vmin[0], c.bat_vmax[0]),
                   pick_volt(c.bat_vmin[1], c.bat_vmax[1]));
      end
      drain();
   endtask

   initial begin
      cfg_type     rand_cfg;
      logic [15:0] lo1, lo2;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: zero period and limit, both enabled, full voltage window
      send_item(OP_ENTER, 32'h0000_0000, 16'h0000, 16'h0000);
      send_item(OP_TICK, 32'h0000_0000, 16'd1000, 16'd1000);
      send_item(OP_TICK, 32'h0000_0001, 16'h8000, 16'h8000);
      send_item(OP_TICK, 32'h0000_0001, 16'hFFFF, 16'h0000);
      send_item(OP_TICK, 32'h0000_0002, 16'hFFFF, 16'h0000);
      send_item(OP_TICK, 32'd200, 16'd100, 16'd200);
      send_item(OP_LEAVE, 32'd201, 16'hFFFF, 16'hFFFF);
      send_item(OP_UNUSED, 32'd5, 16'h1234, 16'h5678);
      send_item(OP_TICK, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      drain();

      // narrow windows; stamps straddle the 32-bit time wrap
      write_settings(make_settings(32'd20, 32'd5, 1'b1, 1'b1,
                                   16'd1000, 16'd100, 16'd2000, 16'd200));
      send_item(OP_ENTER, 32'hFFFF_FFF0, 16'd500, 16'd300);
      send_item(OP_TICK, 32'd5, 16'd500, 16'd300);
      send_item(OP_TICK, 32'd8, 16'd500, 16'd300);
      send_item(OP_TICK, 32'd11, 16'd500, 16'd300);
      send_item(OP_UNUSED, 32'd12, 16'd0, 16'd0);
      send_item(OP_ENTER, 32'd1000, 16'd500, 16'd1500);
      send_item(OP_TICK, 32'd1021, 16'd500, 16'd1500);
      send_item(OP_TICK, 32'd1100, 16'd500, 16'd1500);
      // both cutoffs on one report: one over its max while charging, two under its min
      send_item(OP_TICK, 32'd1103, 16'd1500, 16'd100);
      send_item(OP_TICK, 32'd1125, 16'd50, 16'd2500);
      send_item(OP_LEAVE, 32'd1126, 16'd500, 16'd500);
      drain();

      // every tick swaps roles
      write_settings(make_settings(32'd0, 32'd0, 1'b1, 1'b1,
                                   16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000));
      send_item(OP_ENTER, 32'd0, 16'd0, 16'd0);
      for (int k = 1; k <= 40; k++)
         send_item(OP_TICK, 32'(k), 16'($urandom_range(65535)), 16'($urandom_range(65535)));
      drain();

      run_phase(make_settings(32'd40, 32'd15, 1'b1, 1'b1,
                              16'd50000, 16'd10000, 16'd45000, 16'd12000),
                190, 0, 0, 12, 1'b1);
      run_phase(make_settings(32'd0, 32'd0, 1'b1, 1'b1,
                              16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000),
                180, 52, 0, 4, 1'b0);
      run_phase(make_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1,
                              16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000),
                120, 0, 52, 60, 1'b1);
      run_phase(make_settings(32'd150, 32'd60, 1'b1, 1'b0,
                              16'd40000, 16'd20000, 16'd30000, 16'd5000),
                190, 19, 19, 40, 1'b0);
      run_phase(make_settings(32'd10, 32'd200, 1'b0, 1'b1,
                              16'h0000, 16'hFFFF, 16'd20000, 16'd100),
                190, 19, 19, 8, 1'b1);
      lo1      = 16'($urandom_range(30000));
      lo2      = 16'($urandom_range(30000));
      rand_cfg = make_settings($urandom_range(300, 1), $urandom_range(300),
                               1'($urandom_range(1)), 1'($urandom_range(1)),
                               lo1 + 16'($urandom_range(30000)), lo1,
                               lo2 + 16'($urandom_range(30000)), lo2);
      run_phase(rand_cfg, 230, 0, 52, 30, 1'b0);

      repeat (6) @(posedge clock);
      $display("covered %0d words under %0d register settings with four idle profiles",
               words_sent, settings_used);
      $display("including swaps on every tick, time wrap, both cutoffs and a long rsp hold-off");
      if (mismatch_count == 0 && pending_results == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ===== dual_battery_cycle_controller.f =====
src/dbc_pkg.sv
src/dbc_csr.sv
src/dbc_engine.sv
src/dual_battery_cycle_controller.sv
test/dbc_result_checker.sv
test/dual_battery_cycle_controller_test.sv
